FILE: rtl/tnego_pkg.sv
package tnego_pkg;

	localparam logic [7:0] IAC  = 8'd255;
	localparam logic [7:0] DONT = 8'd254;
	localparam logic [7:0] DO   = 8'd253;
	localparam logic [7:0] WONT = 8'd252;
	localparam logic [7:0] WILL = 8'd251;
	localparam logic [7:0] SB   = 8'd250;
	localparam logic [7:0] SE   = 8'd240;

	localparam logic [7:0] OPT_BINARY  = 8'd0;
	localparam logic [7:0] OPT_ECHO    = 8'd1;
	localparam logic [7:0] OPT_SGA     = 8'd3;
	localparam logic [7:0] OPT_TTYPE   = 8'd24;
	localparam logic [7:0] OPT_NAWS    = 8'd31;
	localparam logic [7:0] OPT_TSPEED  = 8'd32;
	localparam logic [7:0] OPT_OLD_ENV = 8'd36;
	localparam logic [7:0] OPT_NEW_ENV = 8'd39;
	localparam logic [7:0] QUAL_IS     = 8'd0;

	localparam int NUM_OPTS = 10;
	localparam int OPT_IW   = $clog2(NUM_OPTS);

	typedef enum logic [1:0] {
		ST_REQUESTED       = 2'd0,
		ST_ACTIVE          = 2'd1,
		ST_INACTIVE        = 2'd2,
		ST_REALLY_INACTIVE = 2'd3
	} opt_st_t;

	typedef enum logic [2:0] {
		RK_DATA  = 3'd0,
		RK_CMD   = 3'd1,
		RK_START = 3'd2,
		RK_ENV   = 3'd3,
		RK_TTYPE = 3'd4
	} rep_kind_t;

	function automatic logic [7:0] opt_code(logic [OPT_IW-1:0] i);
		case (i)
			4'd0:    return OPT_NAWS;
			4'd1:    return OPT_TSPEED;
			4'd2:    return OPT_TTYPE;
			4'd3:    return OPT_OLD_ENV;
			4'd4:    return OPT_NEW_ENV;
			4'd5:    return OPT_ECHO;
			4'd6:    return OPT_SGA;
			4'd7:    return OPT_SGA;
			default: return OPT_BINARY;
		endcase
	endfunction

	// Entries where we ask the peer to perform the option (DO/DONT side).
	function automatic logic opt_is_do(logic [OPT_IW-1:0] i);
		return (i == 4'd5) || (i == 4'd7) || (i == 4'd9);
	endfunction

	function automatic logic [7:0] opt_req(logic [OPT_IW-1:0] i);
		return opt_is_do(i) ? DO : WILL;
	endfunction

	function automatic logic [7:0] opt_neg(logic [OPT_IW-1:0] i);
		return opt_is_do(i) ? DONT : WONT;
	endfunction

	function automatic logic [7:0] opt_ack(logic [OPT_IW-1:0] i);
		return opt_is_do(i) ? WILL : DO;
	endfunction

	function automatic logic [7:0] opt_nak(logic [OPT_IW-1:0] i);
		return opt_is_do(i) ? WONT : DONT;
	endfunction

	function automatic opt_st_t opt_init(logic [OPT_IW-1:0] i);
		if (i == 4'd3 || i == 4'd8 || i == 4'd9)
			return ST_INACTIVE;
		return ST_REQUESTED;
	endfunction

	function automatic logic [4:0] rep_len(rep_kind_t k);
		case (k)
			RK_DATA:  return 5'd1;
			RK_CMD:   return 5'd3;
			RK_START: return 5'd21;
			RK_ENV:   return 5'd6;
			RK_TTYPE: return 5'd11;
			default:  return 5'd1;
		endcase
	endfunction

	// Requests sent for every option that starts out requested.
	function automatic logic [7:0] start_byte(logic [4:0] i);
		case (i)
			5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18: return IAC;
			5'd1, 5'd4, 5'd7, 5'd10, 5'd16:               return WILL;
			5'd13, 5'd19:                                 return DO;
			5'd2:    return OPT_NAWS;
			5'd5:    return OPT_TSPEED;
			5'd8:    return OPT_TTYPE;
			5'd11:   return OPT_NEW_ENV;
			5'd14:   return OPT_ECHO;
			5'd17:   return OPT_SGA;
			5'd20:   return OPT_SGA;
			default: return IAC;
		endcase
	endfunction

	function automatic logic [7:0] env_byte(logic [4:0] i);
		case (i)
			5'd0:    return IAC;
			5'd1:    return SB;
			5'd2:    return OPT_NEW_ENV;
			5'd3:    return QUAL_IS;
			5'd4:    return IAC;
			default: return SE;
		endcase
	endfunction

	function automatic logic [7:0] ttype_byte(logic [4:0] i);
		case (i)
			5'd0:    return IAC;
			5'd1:    return SB;
			5'd2:    return OPT_TTYPE;
			5'd3:    return QUAL_IS;
			5'd4:    return 8'h78;
			5'd5:    return 8'h74;
			5'd6:    return 8'h65;
			5'd7:    return 8'h72;
			5'd8:    return 8'h6D;
			5'd9:    return IAC;
			default: return SE;
		endcase
	endfunction

endpackage

FILE: rtl/telnet_client_option_negotiator_top.sv
// A request is registered in the input stage on acceptance; its reply is then loaded into the
// reply register, which drives out_valid, once that register is free.
// Throughput: one request per cycle when each yields at most one result byte and out_ready
// is high; a multi-byte reply holds the reply register until all bytes drain (3 for an option
// answer, 6 or 11 for a subnegotiation reply, 21 for a connection start), stalling the input.
// Reset (arst_n low, asynchronous): parser at top level, subnegotiation option zero.
module telnet_client_option_negotiator_top
	import tnego_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       dest,
	output logic [7:0] out_byte,
	output logic       last
);

	typedef enum logic [3:0] {
		PS_TOP     = 4'd0,
		PS_CR      = 4'd1,
		PS_IAC     = 4'd2,
		PS_WILL    = 4'd3,
		PS_WONT    = 4'd4,
		PS_DO      = 4'd5,
		PS_DONT    = 4'd6,
		PS_SB      = 4'd7,
		PS_SUB     = 4'd8,
		PS_SUB_IAC = 4'd9
	} ps_t;

	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;

	ps_t        ps_q, ps_nx;
	logic [7:0] sub_q, sub_nx;
	opt_st_t    opt_q  [NUM_OPTS];
	opt_st_t    opt_nx [NUM_OPTS];

	logic       valid_s2;
	rep_kind_t  rk_s2;
	logic [7:0] byte_s2;
	logic [7:0] cmd_s2;
	logic [4:0] cnt_q;

	logic       advance;
	logic       emit;
	rep_kind_t  rk_nx;
	logic [7:0] cmd_nx;
	logic [7:0] cur_cmd;
	logic [NUM_OPTS-1:0] match;
	logic       hit;
	logic [OPT_IW-1:0] hsel;
	logic       any_ri;

	assign last      = (cnt_q == rep_len(rk_s2) - 5'd1);
	assign out_valid = valid_s2;
	assign dest      = (rk_s2 != RK_DATA);
	assign advance   = valid_s1 && (!valid_s2 || (out_ready && last));
	assign in_ready  = !valid_s1 || advance;

	always_comb begin
		case (ps_q)
			PS_WILL: cur_cmd = WILL;
			PS_WONT: cur_cmd = WONT;
			PS_DO:   cur_cmd = DO;
			default: cur_cmd = DONT;
		endcase
	end

	// Only one table entry can answer a given command for a given option.
	always_comb begin
		hit  = 1'b0;
		hsel = '0;
		for (int i = 0; i < NUM_OPTS; i++) begin
			match[i] = (opt_code(OPT_IW'(i)) == byte_s1) &&
				((opt_ack(OPT_IW'(i)) == cur_cmd) || (opt_nak(OPT_IW'(i)) == cur_cmd));
			if (match[i] && !hit) begin
				hit  = 1'b1;
				hsel = OPT_IW'(i);
			end
		end
	end

	always_comb begin
		ps_nx  = ps_q;
		sub_nx = sub_q;
		opt_nx = opt_q;
		emit   = 1'b0;
		rk_nx  = RK_DATA;
		cmd_nx = cur_cmd;
		if (kind_s1) begin
			ps_nx  = PS_TOP;
			sub_nx = '0;
			for (int i = 0; i < NUM_OPTS; i++)
				opt_nx[i] = opt_init(OPT_IW'(i));
			emit  = 1'b1;
			rk_nx = RK_START;
		end else begin
			case (ps_q)
				PS_IAC: begin
					if (byte_s1 == DO)
						ps_nx = PS_DO;
					else if (byte_s1 == DONT)
						ps_nx = PS_DONT;
					else if (byte_s1 == WILL)
						ps_nx = PS_WILL;
					else if (byte_s1 == WONT)
						ps_nx = PS_WONT;
					else if (byte_s1 == SB)
						ps_nx = PS_SB;
					else
						ps_nx = PS_TOP;
				end
				PS_WILL, PS_WONT, PS_DO, PS_DONT: begin
					ps_nx = PS_TOP;
					rk_nx = RK_CMD;
					if (hit) begin
						if (opt_ack(hsel) == cur_cmd) begin
							case (opt_q[hsel])
								ST_REQUESTED: opt_nx[hsel] = ST_ACTIVE;
								ST_INACTIVE: begin
									opt_nx[hsel] = ST_ACTIVE;
									emit         = 1'b1;
									cmd_nx       = opt_req(hsel);
								end
								ST_REALLY_INACTIVE: begin
									emit   = 1'b1;
									cmd_nx = opt_neg(hsel);
								end
								default: ;
							endcase
						end else begin
							case (opt_q[hsel])
								ST_REQUESTED: opt_nx[hsel] = ST_INACTIVE;
								ST_ACTIVE: begin
									opt_nx[hsel] = ST_INACTIVE;
									emit         = 1'b1;
									cmd_nx       = opt_neg(hsel);
								end
								default: ;
							endcase
						end
					end else if (cur_cmd == WILL || cur_cmd == DO) begin
						// Refuse anything we do not know.
						emit   = 1'b1;
						cmd_nx = (cur_cmd == WILL) ? DONT : WONT;
					end
				end
				PS_SB: begin
					sub_nx = byte_s1;
					ps_nx  = PS_SUB;
				end
				PS_SUB: begin
					if (byte_s1 == IAC)
						ps_nx = PS_SUB_IAC;
				end
				PS_SUB_IAC: begin
					if (byte_s1 == SE) begin
						ps_nx = PS_TOP;
						if (sub_q == OPT_NEW_ENV) begin
							emit  = 1'b1;
							rk_nx = RK_ENV;
						end else if (sub_q == OPT_TTYPE) begin
							emit  = 1'b1;
							rk_nx = RK_TTYPE;
						end
					end
				end
				default: begin
					if (byte_s1 == 8'd0 && ps_q == PS_CR)
						ps_nx = PS_TOP;
					else if (byte_s1 == IAC)
						ps_nx = PS_IAC;
					else begin
						ps_nx = (ps_q == PS_CR) ? PS_CR : PS_TOP;
						emit  = 1'b1;
						rk_nx = RK_DATA;
					end
				end
			endcase
		end
	end

	always_comb begin
		case (rk_s2)
			RK_DATA:  out_byte = byte_s2;
			RK_CMD: begin
				if (cnt_q == 5'd0)
					out_byte = IAC;
				else if (cnt_q == 5'd1)
					out_byte = cmd_s2;
				else
					out_byte = byte_s2;
			end
			RK_START: out_byte = start_byte(cnt_q);
			RK_ENV:   out_byte = env_byte(cnt_q);
			RK_TTYPE: out_byte = ttype_byte(cnt_q);
			default:  out_byte = byte_s2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			kind_s1  <= 1'b0;
			byte_s1  <= '0;
			ps_q     <= PS_TOP;
			sub_q    <= '0;
			for (int i = 0; i < NUM_OPTS; i++)
				opt_q[i] <= opt_init(OPT_IW'(i));
			valid_s2 <= 1'b0;
			rk_s2    <= RK_DATA;
			byte_s2  <= '0;
			cmd_s2   <= '0;
			cnt_q    <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
				if (in_valid) begin
					kind_s1 <= kind;
					byte_s1 <= rx_byte;
				end
			end
			// A new reply can only load once the previous one has fully drained.
			if (advance && emit) begin
				valid_s2 <= 1'b1;
				cnt_q    <= '0;
				rk_s2    <= rk_nx;
				byte_s2  <= byte_s1;
				cmd_s2   <= cmd_nx;
			end else if (valid_s2 && out_ready) begin
				if (last)
					valid_s2 <= 1'b0;
				else
					cnt_q <= cnt_q + 5'd1;
			end
			if (advance) begin
				ps_q  <= ps_nx;
				sub_q <= sub_nx;
				opt_q <= opt_nx;
			end
		end
	end

	always_comb begin
		any_ri = 1'b0;
		for (int i = 0; i < NUM_OPTS; i++)
			any_ri = any_ri || (opt_q[i] == ST_REALLY_INACTIVE);
	end

	// A held request can only be waiting on a reply that is still draining.
	a_stall_only_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> valid_s2)
		else $error("input request stalled with empty reply register");

	a_start_resets_parser: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_s1 |=> ps_q == PS_TOP && sub_q == 8'd0)
		else $error("connection start did not reset the parser");

	a_reply_opens_with_iac: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && dest && cnt_q == 5'd0 |-> out_byte == IAC)
		else $error("reply to peer does not open with IAC");

	a_data_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !dest |-> last)
		else $error("user data byte not marked last");

	// No transition ever leads an option into the really-inactive state.
	a_no_really_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		!any_ri)
		else $error("option reached really-inactive state");

endmodule
